@@ src/prime_factorization_assert.svh @@
// ----------------------------------------------------------------------------
// Prime factorization assertion macros
// Shared property macros for the checker of the prime factorization block.
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTORIZATION_ASSERT_SVH
`define PRIME_FACTORIZATION_ASSERT_SVH

// Implication that must hold in the same cycle.
`define PF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prime factorization check failed");

// Implication that must hold in the following cycle.
`define PF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prime factorization check failed");

`endif

@@ src/pf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factorization package
// Shared constants, result type and controller state type.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int MAX_RESULTS      = 30;
    localparam int FACTOR_WIDTH     = 31;
    localparam int M_TDATA_WIDTH    = ((FACTOR_WIDTH + 7) / 8) * 8;
    localparam int M_TUSER_WIDTH    = 2;

    typedef logic [FACTOR_WIDTH-1:0] factor_t;

    typedef struct packed {
        factor_t factor;
        logic    has_factor;
        logic    is_prime;
        logic    last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } pf_state_t;

endpackage

@@ src/prime_factorization.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factorization
// Factors a signed integer by trial division and streams its prime factors.
// ----------------------------------------------------------------------------
// Each request on the input stream is one signed number; the block returns its
// prime factors in non-decreasing order, one result per factor with repeats,
// and marks the final one with tlast. A number of one or less gives a single
// result with no factor. The block works on one number at a time and is ready
// for the next one as soon as the last result sits in the output register. Each
// trial divisor takes one full pass of the bit-serial divider, and the divisors
// tried are 2 and then the odd numbers up to the root of the remaining value, so
// a 32-bit prime near the top of the range takes far longer than small numbers,
// or numbers whose prime factors are all small.
module prime_factorization import pf_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: number.
    input  logic [((NUMBER_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0: factor, then zero fill.
    output logic [M_TDATA_WIDTH-1:0]               m_axis_tdata,
    // Fields from bit 0: has_factor, is_prime.
    output logic [M_TUSER_WIDTH-1:0]               m_axis_tuser,
    output logic                                   m_axis_tlast
);

    logic                    div_start;
    logic [NUMBER_WIDTH-1:0] div_dividend;
    logic [NUMBER_WIDTH-1:0] div_divisor;
    logic                    div_done;
    logic [NUMBER_WIDTH-1:0] div_quotient;
    logic [NUMBER_WIDTH-1:0] div_remainder;
    logic                    res_valid;
    logic                    res_ready;
    result_t                 res_data;
    result_t                 out_data;

    pf_div #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    pf_ctrl #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_number     (s_axis_tdata[NUMBER_WIDTH-1:0]),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data)
    );

    pf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_data  (res_data),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (out_data)
    );

    assign m_axis_tdata = M_TDATA_WIDTH'(out_data.factor);
    assign m_axis_tuser = {out_data.is_prime, out_data.has_factor};
    assign m_axis_tlast = out_data.last;

endmodule

@@ src/pf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pf_div import pf_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    input  logic [NUMBER_WIDTH-1:0] divisor,
    output logic                    done,
    output logic [NUMBER_WIDTH-1:0] quotient,
    output logic [NUMBER_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(NUMBER_WIDTH);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] quo_reg, quo_next;
    logic [NUMBER_WIDTH-1:0] rem_reg, rem_next;
    logic [NUMBER_WIDTH:0]   shifted;
    logic [NUMBER_WIDTH:0]   diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
        diff      = shifted - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (diff[NUMBER_WIDTH]) begin
                rem_next = shifted[NUMBER_WIDTH-1:0];
                quo_next = {quo_reg[NUMBER_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = diff[NUMBER_WIDTH-1:0];
                quo_next = {quo_reg[NUMBER_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUMBER_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/pf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factorization controller
// Walks the trial divisors, drives the divider and builds each result.
// ----------------------------------------------------------------------------
module pf_ctrl import pf_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] in_number,
    output logic                    div_start,
    output logic [NUMBER_WIDTH-1:0] div_dividend,
    output logic [NUMBER_WIDTH-1:0] div_divisor,
    input  logic                    div_done,
    input  logic [NUMBER_WIDTH-1:0] div_quotient,
    input  logic [NUMBER_WIDTH-1:0] div_remainder,
    output logic                    res_valid,
    input  logic                    res_ready,
    output result_t                 res_data
);

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    pf_state_t               state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] rest_reg, rest_next;
    logic [NUMBER_WIDTH-1:0] trial_reg, trial_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    result_t                 res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        rest_reg  <= rest_next;
        trial_reg <= trial_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        rest_next  = rest_reg;
        trial_next = trial_reg;
        count_next = count_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_number[NUMBER_WIDTH-1] || in_number <= NUMBER_WIDTH'(1)) begin
                        res_next.factor     = '0;
                        res_next.has_factor = 1'b0;
                        res_next.is_prime   = 1'b0;
                        res_next.last       = 1'b1;
                        state_next          = ST_EMIT;
                    end else begin
                        rest_next  = in_number;
                        trial_next = NUMBER_WIDTH'(2);
                        count_next = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (div_quotient < trial_reg) begin
                        // The remaining value has no divisor up to its root, so it is prime.
                        res_next.factor     = factor_t'(rest_reg);
                        res_next.has_factor = 1'b1;
                        res_next.is_prime   = (count_reg == '0);
                        res_next.last       = 1'b1;
                        state_next          = ST_EMIT;
                    end else if (div_remainder == '0) begin
                        res_next.factor     = factor_t'(trial_reg);
                        res_next.has_factor = 1'b1;
                        res_next.is_prime   = 1'b0;
                        res_next.last       = (count_reg == CNT_W'(MAX_RESULTS - 1));
                        rest_next           = div_quotient;
                        count_next          = count_reg + CNT_W'(1);
                        state_next          = ST_EMIT;
                    end else begin
                        // After two, only odd divisors can divide the remaining value.
                        trial_next = (trial_reg == NUMBER_WIDTH'(2)) ? NUMBER_WIDTH'(3)
                                                                      : trial_reg + NUMBER_WIDTH'(2);
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = res_reg.last ? ST_IDLE : ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_dividend = rest_reg;
    assign div_divisor  = trial_reg;
    assign res_data     = res_reg;

endmodule

@@ src/pf_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result for the downstream side so the engine can move on.
// ----------------------------------------------------------------------------
module pf_out import pf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    always_comb begin
        in_ready   = !valid_reg || m_ready;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                data_next = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ src/pf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factorization checker
// Port-level assertions on the result stream of the prime factorization block.
// ----------------------------------------------------------------------------
`include "prime_factorization_assert.svh"

module pf_checker import pf_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [M_TDATA_WIDTH-1:0] m_axis_tdata,
    input logic [M_TUSER_WIDTH-1:0] m_axis_tuser,
    input logic                     m_axis_tlast
);

    `PF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `PF_ASSERT_SAME(a_no_factor_alone, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && !m_axis_tuser[1] && m_axis_tdata == '0)
    `PF_ASSERT_SAME(a_prime_single, aclk, aresetn, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0])
    `PF_ASSERT_SAME(a_factor_at_least_two, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[FACTOR_WIDTH-1:1] != '0)

endmodule

bind prime_factorization pf_checker u_pf_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factorization testbench
// Drives signed numbers into the factorization block over its input stream and
// checks every factor it returns against a trial-division predictor kept in
// the testbench. Directed numbers come first, then a random mix of small
// numbers, smooth large numbers and negative noise, with random stalls on both
// sides, one long stall of the receiver and one pause of the sender until
// every expected factor has come back.
// ----------------------------------------------------------------------------
module tb_top;
    import pf_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam longint LIMIT_CYCLES = 12_000_000;
    localparam int     HOLD_AT      = 20;
    localparam int     HOLD_CYCLES  = 500;

    typedef struct packed {
        logic        drain;
        logic [31:0] number;
    } pending_item_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [31:0]              s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;
    logic [M_TUSER_WIDTH-1:0] m_axis_tuser;
    logic                     m_axis_tlast;

    pending_item_t pending_numbers[$];
    result_t       expected_factors[$];
    int            error_count    = 0;
    int            numbers_sent   = 0;
    int            factors_seen   = 0;
    int            hold_left      = 0;
    bit            hold_done      = 1'b0;

    prime_factorization #(
        .NUMBER_WIDTH(32)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void add_expected(input result_t res);
        expected_factors = {expected_factors, res};
    endfunction

    function automatic void predict_factors(input logic [31:0] number);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned found[$];
        result_t         res;
        logic            prime;
        if (number[31] || number <= 32'd1) begin
            res.factor     = '0;
            res.has_factor = 1'b0;
            res.is_prime   = 1'b0;
            res.last       = 1'b1;
            add_expected(res);
            return;
        end
        rest    = 64'(number);
        divisor = 2;
        while (found.size() < MAX_RESULTS && divisor <= rest / divisor) begin
            while (found.size() < MAX_RESULTS && rest % divisor == 0) begin
                found = {found, divisor};
                rest = rest / divisor;
            end
            divisor++;
        end
        if (found.size() < MAX_RESULTS && rest > 1)
            found = {found, rest};
        prime = (found.size() == 1 && found[0] == 64'(number));
        foreach (found[i]) begin
            res.factor     = factor_t'(found[i]);
            res.has_factor = 1'b1;
            res.is_prime   = prime;
            res.last       = (i == found.size() - 1);
            add_expected(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void queue_number(input logic [31:0] number);
        pending_item_t item;
        item.drain  = 1'b0;
        item.number = number;
        pending_numbers = {pending_numbers, item};
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        pending_item_t next_item;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_factors(s_axis_tdata);
                numbers_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_numbers.size() != 0 && pending_numbers[0].drain &&
                    expected_factors.size() == 0)
                    void'(pending_numbers.pop_front());
                if (pending_numbers.size() == 0 || pending_numbers[0].drain ||
                    (!(numbers_sent >= 50 && numbers_sent < 70) &&
                     $urandom_range(0, 99) < 28)) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_item = pending_numbers.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.number;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                factors_seen++;
                if (expected_factors.size() == 0) begin
                    report_mismatch("unexpected result",
                                    64'({m_axis_tuser, m_axis_tdata}), '0);
                end else begin
                    want = expected_factors.pop_front();
                    if (m_axis_tdata !== M_TDATA_WIDTH'(want.factor))
                        report_mismatch("factor", 64'(m_axis_tdata), 64'(want.factor));
                    if (m_axis_tuser[0] !== want.has_factor)
                        report_mismatch("has_factor", 64'(m_axis_tuser[0]),
                                        64'(want.has_factor));
                    if (m_axis_tuser[1] !== want.is_prime)
                        report_mismatch("is_prime", 64'(m_axis_tuser[1]),
                                        64'(want.is_prime));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && factors_seen == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (factors_seen >= 120 && factors_seen < 180) ||
                                 $urandom_range(0, 99) >= 28;
            end
        end
    end

    initial begin
        pending_item_t   marker;
        longint unsigned value;
        longint unsigned mult;
        int              pick;

        // The power of two comes first so that the long receiver stall lands
        // while further requests are waiting.
        queue_number(32'd1073741824);
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(32'hFFFF_FFFF);
        queue_number(32'h8000_0000);
        queue_number(32'd2);
        queue_number(32'd3);
        queue_number(32'd4);
        queue_number(32'd9);
        queue_number(32'd35);
        queue_number(32'd9409);
        queue_number(32'd65521);
        queue_number(32'd999983);
        queue_number(32'd1431655765);
        queue_number(32'd2147483646);
        queue_number(32'd2147395600);
        queue_number(32'd2147483647);

        marker.drain  = 1'b1;
        marker.number = '0;
        pending_numbers = {pending_numbers, marker};

        repeat (85) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                if ($urandom_range(0, 9) == 0)
                    queue_number($urandom_range(0, 1));
                else
                    queue_number($urandom | 32'h8000_0000);
            end else if (pick < 60) begin
                queue_number($urandom_range(2, 65535));
            end else begin
                value = 1;
                if ($urandom_range(0, 1))
                    value = $urandom_range(2, 1 << 20);
                repeat ($urandom_range(1, 12)) begin
                    mult = $urandom_range(2, 200);
                    if (value * mult <= 64'h7FFF_FFFF)
                        value = value * mult;
                end
                queue_number(value[31:0]);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_numbers.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (expected_factors.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule
